// File: rtl/dlp_pkg.sv
package dlp_pkg;

  localparam int unsigned FIELD_COUNT = 10;

  typedef logic [7:0]  char_t;
  typedef logic [15:0] word_t;
  typedef logic [3:0]  slot_t;

  // Position of each number on the line; the offset minutes share the offset word.
  localparam slot_t SLOT_MINUTE     = 4'd0;
  localparam slot_t SLOT_HOUR       = 4'd1;
  localparam slot_t SLOT_DAY_FIRST  = 4'd2;
  localparam slot_t SLOT_DAY_LAST   = 4'd3;
  localparam slot_t SLOT_MONTH      = 4'd4;
  localparam slot_t SLOT_YEAR_FIRST = 4'd5;
  localparam slot_t SLOT_YEAR_LAST  = 4'd6;
  localparam slot_t SLOT_WDAY_FIRST = 4'd7;
  localparam slot_t SLOT_WDAY_LAST  = 4'd8;
  localparam slot_t SLOT_OFFSET     = 4'd9;
  localparam slot_t SLOT_OFFSET_MIN = 4'd10;

  localparam char_t CH_NUL     = 8'h00;
  localparam char_t CH_TAB     = 8'h09;
  localparam char_t CH_SPACE   = 8'h20;
  localparam char_t CH_HASH    = 8'h23;
  localparam char_t CH_PLUS    = 8'h2B;
  localparam char_t CH_MINUS   = 8'h2D;
  localparam char_t CH_ZERO    = 8'h30;
  localparam char_t CH_NINE    = 8'h39;
  localparam char_t CH_COLON   = 8'h3A;
  localparam char_t CH_UPPER_A = 8'h41;
  localparam char_t CH_UPPER_Z = 8'h5A;
  localparam char_t CH_LOWER_A = 8'h61;
  localparam char_t CH_LOWER_Z = 8'h7A;

  localparam word_t LIMIT_MINUTE  = 16'd59;
  localparam word_t LIMIT_HOUR    = 16'd23;
  localparam word_t LIMIT_DAY     = 16'd31;
  localparam word_t LIMIT_MONTH   = 16'd12;
  localparam word_t LIMIT_WEEKDAY = 16'd6;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGN,
    PH_DIGIT,
    PH_GAP,
    PH_SKIP,
    PH_AFTER_OFF,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ENTRY,
    KIND_HEADING,
    KIND_COMMENT,
    KIND_OTHER
  } kind_t;

  typedef struct packed {
    char_t character;
    logic  line_end;
  } in_beat_t;

  typedef struct packed {
    logic               parse_ok;
    kind_t              line_kind;
    logic [5:0]         minute_of_change;
    logic [4:0]         hour_of_change;
    logic [4:0]         day_first;
    logic [4:0]         day_last;
    logic [3:0]         month_number;
    logic [15:0]        year_first;
    logic [15:0]        year_last;
    logic [2:0]         weekday_first;
    logic [2:0]         weekday_last;
    logic signed [15:0] utc_offset_minutes;
  } result_t;

  typedef struct packed {
    phase_t phase;
    slot_t  slot;
    logic   neg;
    word_t  acc;
    logic   seen;
    logic   fail;
  } entry_t;

  function automatic logic is_blank(char_t c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_digit(char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic kind_t classify(char_t c);
    kind_t k;
    if (is_digit(c)) begin
      k = KIND_ENTRY;
    end else if (((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
                 ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z))) begin
      k = KIND_HEADING;
    end else if (c == CH_HASH) begin
      k = KIND_COMMENT;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

  // Handles the first character seen by a number that starts from a clean state.
  // The low nibble of an ASCII digit is its value.
  function automatic entry_t sign_entry(slot_t slot, char_t c);
    entry_t e;
    e.phase = PH_DIGIT;
    e.slot  = slot;
    e.neg   = 1'b0;
    e.acc   = '0;
    e.seen  = 1'b0;
    e.fail  = 1'b0;
    if (is_blank(c) && (slot >= SLOT_HOUR) && (slot <= SLOT_WDAY_LAST)) begin
      e.phase = PH_SIGN;
    end else if (c == CH_MINUS) begin
      e.neg = 1'b1;
    end else if (is_digit(c)) begin
      e.acc  = {12'd0, c[3:0]};
      e.seen = 1'b1;
    end else if (c != CH_PLUS) begin
      e.fail = 1'b1;
    end
    return e;
  endfunction

endpackage

// File: rtl/dlp_in_if.sv
interface dlp_in_if import dlp_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t character;
  logic  line_end;

  modport source (output valid, character, line_end, input ready);
  modport sink (input valid, character, line_end, output ready);
endinterface

// File: rtl/dlp_out_if.sv
interface dlp_out_if import dlp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               parse_ok;
  kind_t              line_kind;
  logic [5:0]         minute_of_change;
  logic [4:0]         hour_of_change;
  logic [4:0]         day_first;
  logic [4:0]         day_last;
  logic [3:0]         month_number;
  logic [15:0]        year_first;
  logic [15:0]        year_last;
  logic [2:0]         weekday_first;
  logic [2:0]         weekday_last;
  logic signed [15:0] utc_offset_minutes;

  modport source (
    output valid, parse_ok, line_kind, minute_of_change, hour_of_change, day_first,
           day_last, month_number, year_first, year_last, weekday_first, weekday_last,
           utc_offset_minutes,
    input  ready
  );
  modport sink (
    input  valid, parse_ok, line_kind, minute_of_change, hour_of_change, day_first,
           day_last, month_number, year_first, year_last, weekday_first, weekday_last,
           utc_offset_minutes,
    output ready
  );
endinterface

// File: rtl/dlp_in_reg.sv
module dlp_in_reg import dlp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_beat,
  output logic     hold_valid,
  output in_beat_t hold_beat,
  input  logic     take
);

  logic     valid_r;
  logic     valid_nxt;
  in_beat_t beat_r;

  assign in_ready   = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_beat  = beat_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

endmodule

// File: rtl/dlp_parse_core.sv
module dlp_parse_core import dlp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     hold_valid,
  input  in_beat_t hold_beat,
  output logic     take,
  input  logic     res_ready,
  output logic     res_valid,
  output result_t  res
);

  phase_t phase_r, phase_nxt;
  slot_t  slot_r, slot_nxt;
  logic   neg_r, neg_nxt;
  word_t  acc_r, acc_nxt;
  logic   seen_r, seen_nxt;
  logic   failed_r, failed_nxt;
  kind_t  kind_r, kind_nxt;
  word_t  field_r [FIELD_COUNT];

  logic   fld_we;
  slot_t  fld_idx;
  word_t  fld_wdata;

  char_t  cur_char;
  word_t  value;
  word_t  acc_x10;
  word_t  value_x60;
  word_t  offset_nxt;
  logic   ok;

  // The end of the line is handled as a zero byte.
  assign cur_char  = hold_beat.line_end ? CH_NUL : hold_beat.character;
  assign value     = neg_r ? word_t'(16'd0 - acc_r) : acc_r;
  assign acc_x10   = {acc_r[12:0], 3'b000} + {acc_r[14:0], 1'b0};
  assign value_x60 = {value[9:0], 6'b000000} - {value[13:0], 2'b00};

  assign res_valid = hold_valid && hold_beat.line_end;
  assign take      = hold_valid && (!hold_beat.line_end || res_ready);

  always_comb begin : next_state_logic
    entry_t ent;
    logic   use_ent;
    slot_t  ent_slot;
    phase_nxt  = phase_r;
    slot_nxt   = slot_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    seen_nxt   = seen_r;
    failed_nxt = failed_r;
    kind_nxt   = kind_r;
    fld_we     = 1'b0;
    fld_idx    = slot_r;
    fld_wdata  = value;
    use_ent    = 1'b0;
    ent_slot   = slot_r;
    if (!failed_r && (phase_r != PH_DONE)) begin
      unique case (phase_r)
        PH_START: begin
          kind_nxt = classify(cur_char);
          use_ent  = 1'b1;
          ent_slot = SLOT_MINUTE;
        end
        PH_SIGN: begin
          use_ent  = 1'b1;
          ent_slot = slot_r;
        end
        PH_DIGIT: begin
          if (is_digit(cur_char)) begin
            acc_nxt  = acc_x10 + {12'd0, cur_char[3:0]};
            seen_nxt = 1'b1;
          end else if (!seen_r) begin
            failed_nxt = 1'b1;
          end else begin
            case (slot_r) inside
              SLOT_OFFSET_MIN: begin
                fld_we     = 1'b1;
                fld_idx    = SLOT_OFFSET;
                fld_wdata  = field_r[SLOT_OFFSET] + value;
                phase_nxt  = PH_DONE;
              end
              SLOT_OFFSET: begin
                fld_we    = 1'b1;
                fld_idx   = SLOT_OFFSET;
                fld_wdata = value_x60;
                if (is_blank(cur_char)) begin
                  phase_nxt = PH_AFTER_OFF;
                end else if (cur_char == CH_COLON) begin
                  phase_nxt = PH_SIGN;
                  slot_nxt  = SLOT_OFFSET_MIN;
                  neg_nxt   = 1'b0;
                  acc_nxt   = '0;
                  seen_nxt  = 1'b0;
                end else if (cur_char == CH_NUL) begin
                  phase_nxt = PH_DONE;
                end else begin
                  failed_nxt = 1'b1;
                end
              end
              SLOT_DAY_FIRST, SLOT_YEAR_FIRST, SLOT_WDAY_FIRST: begin
                fld_we = 1'b1;
                if (cur_char == CH_SPACE) begin
                  phase_nxt = PH_GAP;
                end else if (cur_char == CH_MINUS) begin
                  phase_nxt = PH_SIGN;
                  slot_nxt  = slot_t'(slot_r + 4'd1);
                  neg_nxt   = 1'b0;
                  acc_nxt   = '0;
                  seen_nxt  = 1'b0;
                end else begin
                  failed_nxt = 1'b1;
                end
              end
              SLOT_WDAY_LAST: begin
                fld_we = 1'b1;
                if (is_digit(cur_char) || (cur_char == CH_MINUS) ||
                    (cur_char == CH_NUL)) begin
                  use_ent  = 1'b1;
                  ent_slot = SLOT_OFFSET;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end
              SLOT_MINUTE, SLOT_HOUR, SLOT_DAY_LAST, SLOT_MONTH, SLOT_YEAR_LAST: begin
                fld_we   = 1'b1;
                use_ent  = 1'b1;
                ent_slot = slot_t'(slot_r + 4'd1);
              end
              default: begin
              end
            endcase
          end
        end
        PH_GAP: begin
          if (is_blank(cur_char)) begin
            phase_nxt = PH_GAP;
          end else if (cur_char == CH_MINUS) begin
            phase_nxt = PH_SIGN;
            slot_nxt  = slot_t'(slot_r + 4'd1);
            neg_nxt   = 1'b0;
            acc_nxt   = '0;
            seen_nxt  = 1'b0;
          end else begin
            // No interval: the last value of the pair is zero.
            fld_we    = 1'b1;
            fld_idx   = slot_t'(slot_r + 4'd1);
            fld_wdata = '0;
            if (slot_r == SLOT_WDAY_FIRST) begin
              if (is_digit(cur_char) || (cur_char == CH_NUL)) begin
                use_ent  = 1'b1;
                ent_slot = SLOT_OFFSET;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end else begin
              use_ent  = 1'b1;
              ent_slot = slot_t'(slot_r + 4'd2);
            end
          end
        end
        PH_SKIP: begin
          if (is_digit(cur_char) || (cur_char == CH_MINUS) || (cur_char == CH_NUL)) begin
            use_ent  = 1'b1;
            ent_slot = SLOT_OFFSET;
          end
        end
        PH_AFTER_OFF: begin
          if (is_blank(cur_char)) begin
            phase_nxt = PH_AFTER_OFF;
          end else if (cur_char == CH_COLON) begin
            phase_nxt = PH_SIGN;
            slot_nxt  = SLOT_OFFSET_MIN;
            neg_nxt   = 1'b0;
            acc_nxt   = '0;
            seen_nxt  = 1'b0;
          end else if (cur_char == CH_NUL) begin
            phase_nxt = PH_DONE;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    ent = sign_entry(ent_slot, cur_char);
    if (use_ent) begin
      phase_nxt  = ent.phase;
      slot_nxt   = ent.slot;
      neg_nxt    = ent.neg;
      acc_nxt    = ent.acc;
      seen_nxt   = ent.seen;
      failed_nxt = ent.fail;
    end
  end

  assign offset_nxt = (fld_we && (fld_idx == SLOT_OFFSET)) ? fld_wdata : field_r[SLOT_OFFSET];

  // A line can only finish cleanly at its end through the offset, so the
  // other fields are already settled in the store when the result is built.
  always_comb begin
    ok = !failed_nxt && (phase_nxt == PH_DONE) &&
         (field_r[SLOT_HOUR] <= LIMIT_HOUR) &&
         (field_r[SLOT_MINUTE] <= LIMIT_MINUTE) &&
         (field_r[SLOT_MONTH] <= LIMIT_MONTH) &&
         ((field_r[SLOT_DAY_LAST] == '0) != (field_r[SLOT_WDAY_LAST] == '0)) &&
         (field_r[SLOT_DAY_FIRST] <= LIMIT_DAY) &&
         (field_r[SLOT_DAY_LAST] <= LIMIT_DAY) &&
         (field_r[SLOT_WDAY_FIRST] <= LIMIT_WEEKDAY) &&
         (field_r[SLOT_WDAY_LAST] <= LIMIT_WEEKDAY);
    res.parse_ok           = ok;
    res.line_kind          = kind_nxt;
    res.minute_of_change   = ok ? field_r[SLOT_MINUTE][5:0] : '0;
    res.hour_of_change     = ok ? field_r[SLOT_HOUR][4:0] : '0;
    res.day_first          = ok ? field_r[SLOT_DAY_FIRST][4:0] : '0;
    res.day_last           = ok ? field_r[SLOT_DAY_LAST][4:0] : '0;
    res.month_number       = ok ? field_r[SLOT_MONTH][3:0] : '0;
    res.year_first         = ok ? field_r[SLOT_YEAR_FIRST] : '0;
    res.year_last          = ok ? field_r[SLOT_YEAR_LAST] : '0;
    res.weekday_first      = ok ? field_r[SLOT_WDAY_FIRST][2:0] : '0;
    res.weekday_last       = ok ? field_r[SLOT_WDAY_LAST][2:0] : '0;
    res.utc_offset_minutes = ok ? $signed(offset_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      slot_r   <= SLOT_MINUTE;
      neg_r    <= 1'b0;
      acc_r    <= '0;
      seen_r   <= 1'b0;
      failed_r <= 1'b0;
      kind_r   <= KIND_ENTRY;
    end else if (take && hold_beat.line_end) begin
      phase_r  <= PH_START;
      slot_r   <= SLOT_MINUTE;
      neg_r    <= 1'b0;
      acc_r    <= '0;
      seen_r   <= 1'b0;
      failed_r <= 1'b0;
      kind_r   <= KIND_ENTRY;
    end else if (take) begin
      phase_r  <= phase_nxt;
      slot_r   <= slot_nxt;
      neg_r    <= neg_nxt;
      acc_r    <= acc_nxt;
      seen_r   <= seen_nxt;
      failed_r <= failed_nxt;
      kind_r   <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fld_we) begin
      field_r[fld_idx] <= fld_wdata;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && hold_beat.line_end) |=> ((phase_r == PH_START) && !failed_r))
    else $error("parser did not return to the line start after a line end");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (failed_r && !(take && hold_beat.line_end)) |=> failed_r)
    else $error("failure cleared before the line end");

  a_ok_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.parse_ok) |->
      ((word_t'(res.hour_of_change) <= LIMIT_HOUR) &&
       (word_t'(res.minute_of_change) <= LIMIT_MINUTE) &&
       (word_t'(res.month_number) <= LIMIT_MONTH)))
    else $error("passing line carries an out-of-range time field");

  a_ok_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.parse_ok) |-> ((res.day_last != '0) != (res.weekday_last != '0)))
    else $error("passing line has both or neither interval end");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.parse_ok) |->
      ((res.year_first == '0) && (res.utc_offset_minutes == '0) && (res.day_first == '0)))
    else $error("failing line carries nonzero fields");

endmodule

// File: rtl/dlp_out_reg.sv
module dlp_out_reg import dlp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  output logic    res_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid && res_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res;
    end
  end

endmodule

// File: rtl/dst_rule_line_parser.sv
// Parses daylight-saving rule lines that arrive one character per beat.
// The input channel carries a character and a line_end flag; a beat with
// line_end set closes the line, its character is ignored, and it produces
// exactly one beat on the result channel. Every other beat produces none.
// A zero character ends the text early; later characters up to line_end
// have no effect.
// Each beat is held in an input register and parsed in the following cycle,
// unless a line_end beat must wait, by one pass of logic over the running
// parse state, so the block takes one beat per cycle back to back while
// results drain; the parser's take of a line_end beat loads its result.
// While the output register holds a result the receiver has not taken,
// character beats keep flowing; only a further line_end beat waits in the
// input register, which then holds off new input until the result moves.
// Synchronous reset empties both registers and puts the parser at the start
// of a line, as does every line_end beat once its result is produced.
module dst_rule_line_parser import dlp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dlp_in_if.sink    in_ch,
  dlp_out_if.source out_ch
);

  in_beat_t in_beat;
  logic     hold_valid;
  in_beat_t hold_beat;
  logic     take;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  result_t  out_res;

  assign in_beat.character = in_ch.character;
  assign in_beat.line_end  = in_ch.line_end;

  dlp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_beat    (in_beat),
    .hold_valid (hold_valid),
    .hold_beat  (hold_beat),
    .take       (take)
  );

  dlp_parse_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid),
    .hold_beat  (hold_beat),
    .take       (take),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  dlp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.parse_ok           = out_res.parse_ok;
  assign out_ch.line_kind          = out_res.line_kind;
  assign out_ch.minute_of_change   = out_res.minute_of_change;
  assign out_ch.hour_of_change     = out_res.hour_of_change;
  assign out_ch.day_first          = out_res.day_first;
  assign out_ch.day_last           = out_res.day_last;
  assign out_ch.month_number       = out_res.month_number;
  assign out_ch.year_first         = out_res.year_first;
  assign out_ch.year_last          = out_res.year_last;
  assign out_ch.weekday_first      = out_res.weekday_first;
  assign out_ch.weekday_last       = out_res.weekday_last;
  assign out_ch.utc_offset_minutes = out_res.utc_offset_minutes;

endmodule

// File: tb/dst_rule_line_parser_test.sv
module dst_rule_line_parser_test;
  import dlp_pkg::*;

  localparam int unsigned PS_LINE_START  = 0;
  localparam int unsigned PS_GAP_BASE    = 23;
  localparam int unsigned PS_SKIP_TEXT   = 26;
  localparam int unsigned PS_OFFSET_TAIL = 27;
  localparam int unsigned PS_FINISHED    = 28;
  localparam int unsigned SCAN_PASSES    = 16;
  localparam int unsigned RANDOM_BEATS   = 1750;
  localparam int unsigned CALM_BEATS     = 300;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  logic clk;
  logic rst_n;

  dlp_in_if in_ch ();
  dlp_out_if out_ch ();

  dst_rule_line_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int unsigned scan_phase;
  bit          scan_neg;
  bit          scan_seen;
  bit          scan_failed;
  word_t       scan_acc;
  kind_t       scan_kind;
  word_t       rule_word [FIELD_COUNT];

  result_t     expected_results [$];
  result_t     due_result;
  char_t       line_buf [$];
  int          gap_odds;
  int          stall_odds;
  int unsigned beats_sent;
  int unsigned lines_closed;
  int unsigned lines_passed;
  int unsigned mismatches;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit blank_char(char_t c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic bit digit_char(char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic kind_t kind_of_char(char_t c);
    if (digit_char(c)) begin
      return KIND_ENTRY;
    end
    if (((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
        ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z))) begin
      return KIND_HEADING;
    end
    if (c == CH_HASH) begin
      return KIND_COMMENT;
    end
    return KIND_OTHER;
  endfunction

  function automatic void clear_scan();
    scan_phase  = PS_LINE_START;
    scan_neg    = 1'b0;
    scan_seen   = 1'b0;
    scan_acc    = '0;
    scan_failed = 1'b0;
    scan_kind   = KIND_ENTRY;
    foreach (rule_word[i]) rule_word[i] = '0;
  endfunction

  function automatic void begin_number(int unsigned slot);
    scan_phase = 1 + 2 * slot;
    scan_neg   = 1'b0;
    scan_seen  = 1'b0;
    scan_acc   = '0;
  endfunction

  // Returns 1 when the character that ended the number has to be scanned again.
  function automatic bit store_number(int unsigned slot, word_t value, char_t c);
    if (slot == SLOT_OFFSET_MIN) begin
      rule_word[SLOT_OFFSET] = rule_word[SLOT_OFFSET] + value;
      scan_phase = PS_FINISHED;
      return 1'b0;
    end
    if (slot == SLOT_OFFSET) begin
      rule_word[SLOT_OFFSET] = value * 16'd60;
      scan_phase = PS_OFFSET_TAIL;
      return 1'b1;
    end
    rule_word[slot] = value;
    if ((slot == SLOT_DAY_FIRST) || (slot == SLOT_YEAR_FIRST) || (slot == SLOT_WDAY_FIRST)) begin
      if (c == CH_SPACE) begin
        scan_phase = PS_GAP_BASE + ((slot == SLOT_DAY_FIRST) ? 0 :
                                    ((slot == SLOT_YEAR_FIRST) ? 1 : 2));
      end else if (c == CH_MINUS) begin
        begin_number(slot + 1);
      end else begin
        scan_failed = 1'b1;
      end
      return 1'b0;
    end
    if (slot == SLOT_WDAY_LAST) begin
      scan_phase = PS_SKIP_TEXT;
      return 1'b1;
    end
    begin_number(slot + 1);
    return 1'b1;
  endfunction

  function automatic void parse_char(char_t c);
    bit          again;
    int unsigned pass;
    int unsigned slot;
    int unsigned first;
    word_t       value;
    again = 1'b1;
    for (pass = 0; again && (pass < SCAN_PASSES); pass++) begin
      again = 1'b0;
      if (scan_failed || (scan_phase >= PS_FINISHED)) begin
        return;
      end
      if (scan_phase == PS_LINE_START) begin
        scan_kind = kind_of_char(c);
        begin_number(SLOT_MINUTE);
        again = 1'b1;
      end else if (scan_phase < PS_GAP_BASE) begin
        slot = (scan_phase - 1) >> 1;
        if (((scan_phase - 1) & 1) == 0) begin
          if (!(blank_char(c) && (slot >= SLOT_HOUR) && (slot <= SLOT_WDAY_LAST))) begin
            scan_phase++;
            if (c == CH_MINUS) begin
              scan_neg = 1'b1;
            end else if (c != CH_PLUS) begin
              again = 1'b1;
            end
          end
        end else if (digit_char(c)) begin
          scan_acc  = scan_acc * 16'd10 + c - CH_ZERO;
          scan_seen = 1'b1;
        end else if (!scan_seen) begin
          scan_failed = 1'b1;
        end else begin
          value = scan_neg ? (16'd0 - scan_acc) : scan_acc;
          again = store_number(slot, value, c);
        end
      end else if (scan_phase < PS_SKIP_TEXT) begin
        first = (scan_phase == PS_GAP_BASE) ? SLOT_DAY_FIRST :
                ((scan_phase == PS_GAP_BASE + 1) ? SLOT_YEAR_FIRST : SLOT_WDAY_FIRST);
        if (!blank_char(c)) begin
          if (c == CH_MINUS) begin
            begin_number(first + 1);
          end else begin
            rule_word[first + 1] = '0;
            if (first == SLOT_WDAY_FIRST) begin
              scan_phase = PS_SKIP_TEXT;
            end else begin
              begin_number(first + 2);
            end
            again = 1'b1;
          end
        end
      end else if (scan_phase == PS_SKIP_TEXT) begin
        if (digit_char(c) || (c == CH_MINUS) || (c == CH_NUL)) begin
          begin_number(SLOT_OFFSET);
          again = 1'b1;
        end
      end else if (!blank_char(c)) begin
        if (c == CH_COLON) begin
          begin_number(SLOT_OFFSET_MIN);
        end else if (c == CH_NUL) begin
          scan_phase = PS_FINISHED;
        end else begin
          scan_failed = 1'b1;
        end
      end
    end
  endfunction

  function automatic result_t close_line();
    result_t r;
    bit      ok;
    if (!scan_failed && (scan_phase != PS_FINISHED)) begin
      parse_char(CH_NUL);
    end
    ok = !scan_failed && (scan_phase == PS_FINISHED);
    if (ok) begin
      if ((rule_word[SLOT_HOUR] > LIMIT_HOUR) || (rule_word[SLOT_MINUTE] > LIMIT_MINUTE) ||
          (rule_word[SLOT_MONTH] > LIMIT_MONTH)) begin
        ok = 1'b0;
      end
      if ((rule_word[SLOT_DAY_LAST] == 0) == (rule_word[SLOT_WDAY_LAST] == 0)) begin
        ok = 1'b0;
      end
      if ((rule_word[SLOT_DAY_FIRST] > LIMIT_DAY) || (rule_word[SLOT_DAY_LAST] > LIMIT_DAY) ||
          (rule_word[SLOT_WDAY_FIRST] > LIMIT_WEEKDAY) ||
          (rule_word[SLOT_WDAY_LAST] > LIMIT_WEEKDAY)) begin
        ok = 1'b0;
      end
    end
    r = '0;
    r.parse_ok  = ok;
    r.line_kind = scan_kind;
    if (ok) begin
      r.minute_of_change   = rule_word[SLOT_MINUTE][5:0];
      r.hour_of_change     = rule_word[SLOT_HOUR][4:0];
      r.day_first          = rule_word[SLOT_DAY_FIRST][4:0];
      r.day_last           = rule_word[SLOT_DAY_LAST][4:0];
      r.month_number       = rule_word[SLOT_MONTH][3:0];
      r.year_first         = rule_word[SLOT_YEAR_FIRST];
      r.year_last          = rule_word[SLOT_YEAR_LAST];
      r.weekday_first      = rule_word[SLOT_WDAY_FIRST][2:0];
      r.weekday_last       = rule_word[SLOT_WDAY_LAST][2:0];
      r.utc_offset_minutes = rule_word[SLOT_OFFSET];
    end
    clear_scan();
    return r;
  endfunction

  task automatic send_beat(char_t c, logic last);
    result_t r;
    if ((gap_odds != 0) && ($urandom_range(1, gap_odds) == 1)) begin
      in_ch.valid     <= 1'b0;
      in_ch.character <= char_t'($urandom_range(0, 255));
      in_ch.line_end  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.character <= c;
    in_ch.line_end  <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    beats_sent++;
    if (last) begin
      r = close_line();
      lines_closed++;
      if (r.parse_ok) begin
        lines_passed++;
      end
      expected_results.push_back(r);
    end else begin
      parse_char(c);
    end
  endtask

  task automatic flush_line();
    foreach (line_buf[i]) send_beat(line_buf[i], 1'b0);
    send_beat(char_t'($urandom_range(0, 255)), 1'b1);
    line_buf.delete();
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(char_t'(s[i]));
  endfunction

  task automatic send_text_line(string s);
    add_text(s);
    flush_line();
  endtask

  function automatic int unsigned pick_value(int unsigned limit, bit nonzero);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return $urandom_range(limit + 1, limit + 9);
    end
    if (r == 1) begin
      return $urandom_range(0, 99999);
    end
    return $urandom_range(nonzero, limit);
  endfunction

  function automatic void add_number(int unsigned v);
    int unsigned r;
    r = $urandom_range(0, 24);
    if (r == 0) begin
      line_buf.push_back(CH_MINUS);
    end else if (r == 1) begin
      line_buf.push_back(CH_PLUS);
    end
    add_text($sformatf("%0d", v));
  endfunction

  function automatic void add_blanks();
    repeat ($urandom_range(1, 2)) begin
      line_buf.push_back(($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE);
    end
  endfunction

  function automatic void add_interval(int unsigned limit, bit with_last);
    add_number(pick_value(limit, 1'b0));
    if (with_last) begin
      case ($urandom_range(0, 2))
        0: add_text("-");
        1: add_text(" -");
        default: add_text(" -\t");
      endcase
      add_number(pick_value(limit, 1'b1));
    end
    add_text(" ");
    if ($urandom_range(0, 3) == 0) begin
      add_blanks();
    end
  endfunction

  // Mostly well-formed rule lines with random content, so that most lines
  // reach the offset and the plausibility checks.
  function automatic void build_rule_line();
    bit by_day;
    int unsigned lead;
    lead = $urandom_range(0, 15);
    if (lead == 0) begin
      line_buf.push_back(CH_HASH);
    end else if (lead == 1) begin
      line_buf.push_back(char_t'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
    end else if (lead == 2) begin
      line_buf.push_back(char_t'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
    end else if (lead == 3) begin
      line_buf.push_back(CH_SPACE);
    end
    by_day = 1'($urandom_range(0, 1));
    add_number(pick_value(LIMIT_MINUTE, 1'b0));
    add_blanks();
    add_number(pick_value(LIMIT_HOUR, 1'b0));
    add_blanks();
    add_interval(LIMIT_DAY, by_day ^ ($urandom_range(0, 15) == 0));
    add_number(pick_value(LIMIT_MONTH, 1'b0));
    add_blanks();
    add_interval(16'hFFFF, 1'($urandom_range(0, 1)));
    add_interval(LIMIT_WEEKDAY, !by_day ^ ($urandom_range(0, 15) == 0));
    case ($urandom_range(0, 4))
      0: add_text("");
      1: add_text("UTC");
      2: add_text("GMT+");
      3: add_text("+");
      default: add_text("dst ");
    endcase
    if ($urandom_range(0, 2) == 0) begin
      line_buf.push_back(CH_MINUS);
    end
    add_text($sformatf("%0d", ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99999) :
                                                           $urandom_range(0, 14)));
    if ($urandom_range(0, 1) == 1) begin
      line_buf.push_back(CH_COLON);
      add_text($sformatf("%0d", ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99999) :
                                                             $urandom_range(0, 59)));
    end
    case ($urandom_range(0, 3))
      0: add_text("");
      1: add_text(" ; note");
      2: begin
        line_buf.push_back(CH_NUL);
        line_buf.push_back(char_t'($urandom_range(0, 255)));
      end
      default: add_text("\t x");
    endcase
  endfunction

  function automatic void damage_line();
    int unsigned spot;
    spot = $urandom_range(0, line_buf.size() - 1);
    case ($urandom_range(0, 2))
      0: while (line_buf.size() > spot) void'(line_buf.pop_back());
      1: line_buf[spot] = char_t'($urandom_range(0, 255));
      default: line_buf.insert(spot, CH_NUL);
    endcase
  endfunction

  task automatic test_line_kinds();
    send_text_line("#a");
    send_text_line("Q");
    send_text_line("");
    send_text_line("~");
  endtask

  task automatic test_field_extremes();
    send_text_line("0 0 0 0 0-0 0-6 0");
    send_text_line("59 23 31-31 12 65535-1 6 UTC-14:59");
  endtask

  task automatic test_number_forms();
    send_text_line("12+5\t+1 -2 3 4-5 6 x+1:7 ok");
    send_text_line("65541 -0 1-2 3 4 5 x99999");
  endtask

  task automatic test_text_end();
    add_text("1 2 3-4 5 6 7 x8");
    line_buf.push_back(CH_NUL);
    add_text("zz");
    flush_line();
    send_text_line("1 2 3-4 5 6 7 x8:");
  endtask

  task automatic test_plausibility();
    send_text_line("1 2 3-4 5 6 0-1 x0");
    send_text_line("60 24 32-40 13 1 7-7 x0");
  endtask

  task automatic test_random_lines();
    int unsigned stop_at;
    int unsigned shape;
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      if (beats_sent + CALM_BEATS >= stop_at) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
        stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
      end
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        repeat ($urandom_range(0, 10)) line_buf.push_back(char_t'($urandom_range(0, 255)));
      end else begin
        build_rule_line();
        if (shape == 1) begin
          damage_line();
        end
      end
      flush_line();
    end
  endtask

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with no line pending, parse_ok %0b", $time,
                 out_ch.parse_ok);
      end else begin
        due_result = expected_results.pop_front();
        check_field("parse_ok", due_result.parse_ok, out_ch.parse_ok);
        check_field("line_kind", due_result.line_kind, out_ch.line_kind);
        check_field("minute_of_change", due_result.minute_of_change, out_ch.minute_of_change);
        check_field("hour_of_change", due_result.hour_of_change, out_ch.hour_of_change);
        check_field("day_first", due_result.day_first, out_ch.day_first);
        check_field("day_last", due_result.day_last, out_ch.day_last);
        check_field("month_number", due_result.month_number, out_ch.month_number);
        check_field("year_first", due_result.year_first, out_ch.year_first);
        check_field("year_last", due_result.year_last, out_ch.year_last);
        check_field("weekday_first", due_result.weekday_first, out_ch.weekday_first);
        check_field("weekday_last", due_result.weekday_last, out_ch.weekday_last);
        check_field("utc_offset_minutes", due_result.utc_offset_minutes,
                    out_ch.utc_offset_minutes);
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ((stall_odds != 0) && ($urandom_range(1, stall_odds) == 1)) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("dst_rule_line_parser_test NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.character <= CH_NUL;
    in_ch.line_end  <= 1'b0;
    gap_odds     = 4;
    stall_odds   = 4;
    beats_sent   = 0;
    lines_closed = 0;
    lines_passed = 0;
    mismatches   = 0;
    cycle_count  = 0;
    clear_scan();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_line_kinds();
    test_field_extremes();
    test_number_forms();
    test_text_end();
    test_plausibility();
    test_random_lines();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d beats making up %0d lines, with %0d lines passing every check.",
             beats_sent, lines_closed, lines_passed);
    if (mismatches == 0) begin
      $display("dst_rule_line_parser_test OK");
    end else begin
      $display("dst_rule_line_parser_test NOT OK");
    end
    $finish;
  end

endmodule
